// ===== sv/nbv_pkg.sv =====
// Shared types, constants and fixed-point helpers for the N-body Verlet step core.
package nbv_pkg;

  localparam logic [63:0] SMAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 41;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_BAND      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MIN_STEPS = 2'd2;

  localparam logic [40:0] STEP_SIZE_RST        = 41'd109951162778;
  localparam logic [40:0] PERIOD_BAND_RST      = 41'd10995116278;
  localparam logic [31:0] PERIOD_MIN_STEPS_RST = 32'd500;

  // r3 at or below this saturates the inverse
  localparam logic [63:0]  TINY_R3      = 64'd131072;
  // remainder of 2^80 / d after the quotient bits that are always zero
  localparam logic [63:0]  DIV_REM_INIT = 64'd131072;
  localparam logic [127:0] ROUND_HALF   = 128'h80_0000_0000;

  localparam logic [5:0] SQRT_LAST = 6'd51;
  localparam logic [5:0] DIV_LAST  = 6'd62;
  localparam logic [2:0] MUL_LAST  = 3'd5;
  localparam logic [2:0] MUL_PARTS = 3'd4;

  typedef struct packed {
    logic                operation;
    logic [3:0]          body_index;
    logic [40:0]         body_mass;
    logic signed [63:0]  load_pos_x;
    logic signed [63:0]  load_pos_y;
    logic signed [63:0]  load_vel_x;
    logic signed [63:0]  load_vel_y;
  } item_t;

  typedef struct packed {
    logic [3:0]          out_body;
    logic signed [63:0]  out_pos_x;
    logic signed [63:0]  out_pos_y;
    logic                period_hit;
    logic [31:0]         out_step;
    logic                last;
  } result_t;

  typedef struct packed {
    logic [40:0] mass;
    logic [63:0] px;
    logic [63:0] py;
    logic [63:0] vx;
    logic [63:0] vy;
  } body_t;

  typedef struct packed {
    logic [63:0] ax;
    logic [63:0] ay;
  } accel_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_HH, ST_HHW,
    ST_A_RDI, ST_A_LDI, ST_A_RDJ, ST_A_DIFF,
    ST_A_M1, ST_A_M1W, ST_A_M2, ST_A_M2W, ST_A_CHK, ST_A_SQRT,
    ST_A_M3, ST_A_M3W, ST_A_INV, ST_A_DIV,
    ST_A_M4, ST_A_M4W, ST_A_M5, ST_A_M5W, ST_A_M6, ST_A_M6W, ST_A_M7, ST_A_M7W,
    ST_A_NEXTJ,
    ST_E_RD, ST_E_PUT,
    ST_U_RD, ST_U_M1, ST_U_M1W, ST_U_M2, ST_U_M2W, ST_U_M3, ST_U_M3W,
    ST_U_M4, ST_U_M4W,
    ST_V_RD, ST_V_RD2, ST_V_SUM, ST_V_M1, ST_V_M1W, ST_V_M2, ST_V_M2W,
    ST_FIN
  } state_t;

  function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] ssub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // acc already holds |a*b| plus one half LSB of the Q24.40 result
  function automatic logic [63:0] mulq_round(input logic [127:0] acc, input logic neg);
    logic [63:0] m;
    m = acc[103:40];
    if (|acc[127:104]) return neg ? SMIN : SMAX;
    if (neg) return m[63] ? SMIN : (64'd0 - m);
    return m[63] ? SMAX : m;
  endfunction

endpackage

// ===== sv/nbv_mulq.sv =====
// Shared Q24.40 multiplier: 64x64 magnitude product from four 32x32 partials.
module nbv_mulq (
  input  logic              clk,
  input  logic              rst,
  input  nbv_pkg::mul_req_t req,
  output nbv_pkg::mul_rsp_t rsp
);

  logic         active;
  logic [2:0]   cnt;
  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         neg;
  logic [63:0]  pp;
  logic [1:0]   psh;
  logic [127:0] acc;
  logic [127:0] pp_shifted;
  logic [31:0]  a_part;
  logic [31:0]  b_part;
  logic         done_q;
  logic [63:0]  product_q;

  assign a_part = (cnt[1]) ? ma[63:32] : ma[31:0];
  assign b_part = (cnt[0]) ? mb[63:32] : mb[31:0];

  assign rsp = '{done: done_q, product: product_q};

  always_comb begin
    case (psh)
      2'd0:    pp_shifted = {64'd0, pp};
      2'd1:    pp_shifted = {32'd0, pp, 32'd0};
      default: pp_shifted = {pp, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done_q <= 1'b0;
      cnt    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 3'd1;
        if (cnt == nbv_pkg::MUL_LAST) begin
          active <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // partial product registered, accumulated in the next cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      ma  <= nbv_pkg::mag(req.a);
      mb  <= nbv_pkg::mag(req.b);
      neg <= req.a[63] ^ req.b[63];
      acc <= nbv_pkg::ROUND_HALF;
    end else if (active) begin
      if (cnt < nbv_pkg::MUL_PARTS) begin
        pp  <= a_part * b_part;
        psh <= 2'(cnt[0]) + 2'(cnt[1]);
      end
      if (cnt != 3'd0 && cnt <= nbv_pkg::MUL_PARTS) acc <= acc + pp_shifted;
      if (cnt == nbv_pkg::MUL_LAST) product_q <= nbv_pkg::mulq_round(acc, neg);
    end
  end

endmodule

// ===== sv/nbody_verlet_step_core.sv =====
// Two-dimensional gravitational N-body integrator (velocity Verlet, Q24.40).
// A load beat writes one body (an index at or above BODIES is dropped) and gives
// no result. A step beat gives BODIES result beats, body 0 first, and then advances
// the system. The time is set by the pairwise acceleration pass: each of the
// BODIES*(BODIES-1) ordered pairs runs two multiplies on the shared 4-partial
// multiplier; a pair that is not coincident runs five more, a square root and,
// unless r3 is tiny, a divide. A step costs one pass, two after reset or any load,
// plus the position and velocity updates and the result beats. Body state sits in
// one single-port memory and the accelerations in a second, double-banked one.
module nbody_verlet_step_core #(
  parameter int BODIES = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  nbv_pkg::item_t                      item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output nbv_pkg::result_t                    result,
  input  logic                                cfg_we,
  input  logic [nbv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nbv_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW        = $clog2(BODIES);
  localparam int ACC_DEPTH = 2 ** (AW + 1);
  localparam logic [AW-1:0] LAST = AW'(BODIES - 1);
  localparam logic [4:0]    BODY_LIMIT = 5'(BODIES);

  nbv_pkg::state_t state, state_next;

  // configuration
  logic [40:0] step_size;
  logic [40:0] period_band;
  logic [31:0] period_min_steps;

  // control
  logic [AW-1:0]     bi;
  logic [AW-1:0]     bj;
  logic              abank;
  logic              second;
  logic              accel_valid;
  logic [31:0]       step_counter;
  logic [BODIES-1:0] period_seen;

  // datapath
  logic [63:0] pix, piy, dx, dy, t, r2, r3, inv, sx, sy, nx, oax, oay, sumx, sumy, hh;
  logic [40:0] mj;
  logic [103:0] sq_n;
  logic [55:0]  sq_r;
  logic [51:0]  root;
  logic [63:0]  dv_rem;
  logic [62:0]  dv_q;
  logic [5:0]   cnt;

  // memories
  nbv_pkg::body_t  body_mem [0:BODIES-1];
  nbv_pkg::accel_t acc_mem  [0:ACC_DEPTH-1];
  nbv_pkg::body_t  body_q, body_wd;
  nbv_pkg::accel_t acc_q, acc_wd;
  logic            body_re, body_we, acc_re, acc_we;
  logic [AW-1:0]   body_ra, body_wa;
  logic [AW:0]     acc_ra, acc_wa;
  logic            wbank;

  nbv_pkg::mul_req_t mreq;
  nbv_pkg::mul_rsp_t mrsp;

  logic [63:0]  h_s, hh2_s, mj_s, band64;
  logic [55:0]  sq_rr, sq_tt;
  logic         sq_ge;
  logic [51:0]  root_n;
  logic [63:0]  dv_rr;
  logic         dv_ge;
  logic [62:0]  dv_q_n;
  logic         hit;
  logic         room;
  logic         emit;
  logic         idx_ok;

  nbv_mulq u_mulq (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  assign h_s    = {23'd0, step_size};
  assign hh2_s  = {24'd0, step_size[40:1]};
  assign mj_s   = {23'd0, mj};
  assign band64 = {23'd0, period_band};
  assign wbank  = second ? ~abank : abank;
  assign room   = !result_valid || !result_stall;
  assign idx_ok = {1'b0, item.body_index} < BODY_LIMIT;

  assign sq_rr  = {sq_r[53:0], sq_n[103:102]};
  assign sq_tt  = {2'b00, root, 2'b01};
  assign sq_ge  = sq_rr >= sq_tt;
  assign root_n = {root[50:0], sq_ge};

  assign dv_rr  = {dv_rem[62:0], 1'b0};
  assign dv_ge  = dv_rr >= r3;
  assign dv_q_n = {dv_q[61:0], dv_ge};

  assign hit = (bi != '0) && !period_seen[bi] &&
               ($signed(body_q.py) < $signed(band64)) &&
               ($signed(body_q.py) > $signed(64'd0 - band64)) &&
               !body_q.px[63] && (body_q.px != 64'd0) &&
               (step_counter > period_min_steps);

  // memory ports
  always_ff @(posedge clk) begin
    if (body_we) body_mem[body_wa] <= body_wd;
    if (body_re) body_q <= body_mem[body_ra];
  end

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_wa] <= acc_wd;
    if (acc_re) acc_q <= acc_mem[acc_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= nbv_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    item_stall = 1'b1;
    emit       = 1'b0;
    body_re    = 1'b0;
    body_ra    = bi;
    body_we    = 1'b0;
    body_wa    = bi;
    body_wd    = body_q;
    acc_re     = 1'b0;
    acc_ra     = {abank, bi};
    acc_we     = 1'b0;
    acc_wa     = {wbank, bi};
    acc_wd     = {sx, sy};
    mreq.start = 1'b0;
    mreq.a     = dx;
    mreq.b     = dx;
    case (state)
      nbv_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          if (item.operation == nbv_pkg::OP_LOAD) begin
            body_we      = idx_ok;
            body_wa      = item.body_index[AW-1:0];
            body_wd.mass = item.body_mass;
            body_wd.px   = item.load_pos_x;
            body_wd.py   = item.load_pos_y;
            body_wd.vx   = item.load_vel_x;
            body_wd.vy   = item.load_vel_y;
          end else begin
            state_next = nbv_pkg::ST_HH;
          end
        end
      end
      nbv_pkg::ST_HH: begin
        mreq.start = 1'b1;
        mreq.a     = h_s;
        mreq.b     = h_s;
        state_next = nbv_pkg::ST_HHW;
      end
      nbv_pkg::ST_HHW: begin
        if (mrsp.done) state_next = accel_valid ? nbv_pkg::ST_E_RD : nbv_pkg::ST_A_RDI;
      end
      // acceleration pass
      nbv_pkg::ST_A_RDI: begin
        body_re    = 1'b1;
        state_next = nbv_pkg::ST_A_LDI;
      end
      nbv_pkg::ST_A_LDI: state_next = nbv_pkg::ST_A_RDJ;
      nbv_pkg::ST_A_RDJ: begin
        if (bj == bi) begin
          state_next = nbv_pkg::ST_A_NEXTJ;
        end else begin
          body_re    = 1'b1;
          body_ra    = bj;
          state_next = nbv_pkg::ST_A_DIFF;
        end
      end
      nbv_pkg::ST_A_DIFF: state_next = nbv_pkg::ST_A_M1;
      nbv_pkg::ST_A_M1: begin
        mreq.start = 1'b1;
        state_next = nbv_pkg::ST_A_M1W;
      end
      nbv_pkg::ST_A_M1W: if (mrsp.done) state_next = nbv_pkg::ST_A_M2;
      nbv_pkg::ST_A_M2: begin
        mreq.start = 1'b1;
        mreq.a     = dy;
        mreq.b     = dy;
        state_next = nbv_pkg::ST_A_M2W;
      end
      nbv_pkg::ST_A_M2W: if (mrsp.done) state_next = nbv_pkg::ST_A_CHK;
      nbv_pkg::ST_A_CHK: begin
        // coincident bodies contribute nothing
        state_next = (r2 == 64'd0) ? nbv_pkg::ST_A_NEXTJ : nbv_pkg::ST_A_SQRT;
      end
      nbv_pkg::ST_A_SQRT: if (cnt == 6'd0) state_next = nbv_pkg::ST_A_M3;
      nbv_pkg::ST_A_M3: begin
        mreq.start = 1'b1;
        mreq.a     = r2;
        mreq.b     = {12'd0, root};
        state_next = nbv_pkg::ST_A_M3W;
      end
      nbv_pkg::ST_A_M3W: if (mrsp.done) state_next = nbv_pkg::ST_A_INV;
      nbv_pkg::ST_A_INV: begin
        state_next = ($signed(r3) <= $signed(nbv_pkg::TINY_R3)) ?
                     nbv_pkg::ST_A_M4 : nbv_pkg::ST_A_DIV;
      end
      nbv_pkg::ST_A_DIV: if (cnt == 6'd0) state_next = nbv_pkg::ST_A_M4;
      nbv_pkg::ST_A_M4: begin
        mreq.start = 1'b1;
        mreq.a     = mj_s;
        mreq.b     = dx;
        state_next = nbv_pkg::ST_A_M4W;
      end
      nbv_pkg::ST_A_M4W: if (mrsp.done) state_next = nbv_pkg::ST_A_M5;
      nbv_pkg::ST_A_M5: begin
        mreq.start = 1'b1;
        mreq.a     = t;
        mreq.b     = inv;
        state_next = nbv_pkg::ST_A_M5W;
      end
      nbv_pkg::ST_A_M5W: if (mrsp.done) state_next = nbv_pkg::ST_A_M6;
      nbv_pkg::ST_A_M6: begin
        mreq.start = 1'b1;
        mreq.a     = mj_s;
        mreq.b     = dy;
        state_next = nbv_pkg::ST_A_M6W;
      end
      nbv_pkg::ST_A_M6W: if (mrsp.done) state_next = nbv_pkg::ST_A_M7;
      nbv_pkg::ST_A_M7: begin
        mreq.start = 1'b1;
        mreq.a     = t;
        mreq.b     = inv;
        state_next = nbv_pkg::ST_A_M7W;
      end
      nbv_pkg::ST_A_M7W: if (mrsp.done) state_next = nbv_pkg::ST_A_NEXTJ;
      nbv_pkg::ST_A_NEXTJ: begin
        if (bj != LAST) begin
          state_next = nbv_pkg::ST_A_RDJ;
        end else begin
          acc_we = 1'b1;
          if (bi != LAST) state_next = nbv_pkg::ST_A_RDI;
          else            state_next = second ? nbv_pkg::ST_V_RD : nbv_pkg::ST_E_RD;
        end
      end
      // result beats
      nbv_pkg::ST_E_RD: begin
        body_re    = 1'b1;
        state_next = nbv_pkg::ST_E_PUT;
      end
      nbv_pkg::ST_E_PUT: begin
        if (room) begin
          emit       = 1'b1;
          state_next = (bi == LAST) ? nbv_pkg::ST_U_RD : nbv_pkg::ST_E_RD;
        end
      end
      // position update
      nbv_pkg::ST_U_RD: begin
        body_re    = 1'b1;
        acc_re     = 1'b1;
        state_next = nbv_pkg::ST_U_M1;
      end
      nbv_pkg::ST_U_M1: begin
        mreq.start = 1'b1;
        mreq.a     = h_s;
        mreq.b     = body_q.vx;
        state_next = nbv_pkg::ST_U_M1W;
      end
      nbv_pkg::ST_U_M1W: if (mrsp.done) state_next = nbv_pkg::ST_U_M2;
      nbv_pkg::ST_U_M2: begin
        mreq.start = 1'b1;
        mreq.a     = hh;
        mreq.b     = acc_q.ax;
        state_next = nbv_pkg::ST_U_M2W;
      end
      nbv_pkg::ST_U_M2W: if (mrsp.done) state_next = nbv_pkg::ST_U_M3;
      nbv_pkg::ST_U_M3: begin
        mreq.start = 1'b1;
        mreq.a     = h_s;
        mreq.b     = body_q.vy;
        state_next = nbv_pkg::ST_U_M3W;
      end
      nbv_pkg::ST_U_M3W: if (mrsp.done) state_next = nbv_pkg::ST_U_M4;
      nbv_pkg::ST_U_M4: begin
        mreq.start = 1'b1;
        mreq.a     = hh;
        mreq.b     = acc_q.ay;
        state_next = nbv_pkg::ST_U_M4W;
      end
      nbv_pkg::ST_U_M4W: begin
        if (mrsp.done) begin
          body_we    = 1'b1;
          body_wd.px = nx;
          body_wd.py = nbv_pkg::sadd(body_q.py, nbv_pkg::sadd(t, mrsp.product));
          state_next = (bi == LAST) ? nbv_pkg::ST_A_RDI : nbv_pkg::ST_U_RD;
        end
      end
      // velocity update: old accel in abank, new in the other bank
      nbv_pkg::ST_V_RD: begin
        body_re    = 1'b1;
        acc_re     = 1'b1;
        state_next = nbv_pkg::ST_V_RD2;
      end
      nbv_pkg::ST_V_RD2: begin
        acc_re     = 1'b1;
        acc_ra     = {~abank, bi};
        state_next = nbv_pkg::ST_V_SUM;
      end
      nbv_pkg::ST_V_SUM: state_next = nbv_pkg::ST_V_M1;
      nbv_pkg::ST_V_M1: begin
        mreq.start = 1'b1;
        mreq.a     = hh2_s;
        mreq.b     = sumx;
        state_next = nbv_pkg::ST_V_M1W;
      end
      nbv_pkg::ST_V_M1W: if (mrsp.done) state_next = nbv_pkg::ST_V_M2;
      nbv_pkg::ST_V_M2: begin
        mreq.start = 1'b1;
        mreq.a     = hh2_s;
        mreq.b     = sumy;
        state_next = nbv_pkg::ST_V_M2W;
      end
      nbv_pkg::ST_V_M2W: begin
        if (mrsp.done) begin
          body_we    = 1'b1;
          body_wd.vx = nx;
          body_wd.vy = nbv_pkg::sadd(body_q.vy, mrsp.product);
          state_next = (bi == LAST) ? nbv_pkg::ST_FIN : nbv_pkg::ST_V_RD;
        end
      end
      nbv_pkg::ST_FIN: state_next = nbv_pkg::ST_IDLE;
      default: state_next = nbv_pkg::ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size        <= nbv_pkg::STEP_SIZE_RST;
      period_band      <= nbv_pkg::PERIOD_BAND_RST;
      period_min_steps <= nbv_pkg::PERIOD_MIN_STEPS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        nbv_pkg::REG_STEP_SIZE:        step_size        <= cfg_data;
        nbv_pkg::REG_PERIOD_BAND:      period_band      <= cfg_data;
        nbv_pkg::REG_PERIOD_MIN_STEPS: period_min_steps <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bi           <= '0;
      bj           <= '0;
      abank        <= 1'b0;
      second       <= 1'b0;
      accel_valid  <= 1'b0;
      step_counter <= '0;
      period_seen  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (emit) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
      case (state)
        nbv_pkg::ST_IDLE: begin
          if (item_valid) begin
            if (item.operation == nbv_pkg::OP_LOAD) accel_valid <= 1'b0;
            else second <= 1'b0;
          end
        end
        nbv_pkg::ST_HHW: bi <= '0;
        nbv_pkg::ST_A_LDI: bj <= '0;
        nbv_pkg::ST_A_NEXTJ: begin
          if (bj != LAST) bj <= bj + 1'b1;
          else if (bi != LAST) bi <= bi + 1'b1;
          else bi <= '0;
        end
        nbv_pkg::ST_E_PUT: begin
          if (emit) begin
            if (hit) period_seen[bi] <= 1'b1;
            bi <= (bi == LAST) ? '0 : bi + 1'b1;
          end
        end
        nbv_pkg::ST_U_M4W: begin
          if (mrsp.done) begin
            if (bi == LAST) begin
              bi     <= '0;
              second <= 1'b1;
            end else begin
              bi <= bi + 1'b1;
            end
          end
        end
        nbv_pkg::ST_V_M2W: if (mrsp.done && bi != LAST) bi <= bi + 1'b1;
        nbv_pkg::ST_FIN: begin
          abank        <= ~abank;
          accel_valid  <= 1'b1;
          step_counter <= step_counter + 32'd1;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      result.out_body   <= 4'(bi);
      result.out_pos_x  <= body_q.px;
      result.out_pos_y  <= body_q.py;
      result.period_hit <= hit;
      result.out_step   <= step_counter;
      result.last       <= (bi == LAST);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      nbv_pkg::ST_HHW: if (mrsp.done) hh <= {1'b0, mrsp.product[63:1]};
      nbv_pkg::ST_A_LDI: begin
        pix <= body_q.px;
        piy <= body_q.py;
        sx  <= '0;
        sy  <= '0;
      end
      nbv_pkg::ST_A_DIFF: begin
        dx <= nbv_pkg::ssub(pix, body_q.px);
        dy <= nbv_pkg::ssub(piy, body_q.py);
        mj <= body_q.mass;
      end
      nbv_pkg::ST_A_M1W: if (mrsp.done) t <= mrsp.product;
      nbv_pkg::ST_A_M2W: if (mrsp.done) r2 <= nbv_pkg::sadd(t, mrsp.product);
      nbv_pkg::ST_A_CHK: begin
        sq_n <= {r2, 40'd0};
        sq_r <= '0;
        root <= '0;
        cnt  <= nbv_pkg::SQRT_LAST;
      end
      nbv_pkg::ST_A_SQRT: begin
        sq_n <= {sq_n[101:0], 2'b00};
        sq_r <= sq_ge ? (sq_rr - sq_tt) : sq_rr;
        root <= root_n;
        cnt  <= cnt - 6'd1;
      end
      nbv_pkg::ST_A_M3W: if (mrsp.done) r3 <= mrsp.product;
      nbv_pkg::ST_A_INV: begin
        inv    <= nbv_pkg::SMAX;
        dv_rem <= nbv_pkg::DIV_REM_INIT;
        dv_q   <= '0;
        cnt    <= nbv_pkg::DIV_LAST;
      end
      nbv_pkg::ST_A_DIV: begin
        dv_rem <= dv_ge ? (dv_rr - r3) : dv_rr;
        dv_q   <= dv_q_n;
        cnt    <= cnt - 6'd1;
        if (cnt == 6'd0) inv <= {1'b0, dv_q_n};
      end
      nbv_pkg::ST_A_M4W: if (mrsp.done) t <= mrsp.product;
      nbv_pkg::ST_A_M5W: if (mrsp.done) sx <= nbv_pkg::ssub(sx, mrsp.product);
      nbv_pkg::ST_A_M6W: if (mrsp.done) t <= mrsp.product;
      nbv_pkg::ST_A_M7W: if (mrsp.done) sy <= nbv_pkg::ssub(sy, mrsp.product);
      nbv_pkg::ST_U_M1W: if (mrsp.done) t <= mrsp.product;
      nbv_pkg::ST_U_M2W: begin
        if (mrsp.done) nx <= nbv_pkg::sadd(body_q.px, nbv_pkg::sadd(t, mrsp.product));
      end
      nbv_pkg::ST_U_M3W: if (mrsp.done) t <= mrsp.product;
      nbv_pkg::ST_V_RD2: begin
        oax <= acc_q.ax;
        oay <= acc_q.ay;
      end
      nbv_pkg::ST_V_SUM: begin
        sumx <= nbv_pkg::sadd(oax, acc_q.ax);
        sumy <= nbv_pkg::sadd(oay, acc_q.ay);
      end
      nbv_pkg::ST_V_M1W: if (mrsp.done) nx <= nbv_pkg::sadd(body_q.vx, mrsp.product);
      default: ;
    endcase
  end

endmodule

// ===== tb/sv/nbv_checker.sv =====
// Checker for the N-body Verlet step core: predicts positions and period flags, compares beats.
`timescale 1ns / 1ps
module nbv_checker #(
  parameter int BODIES = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  input  logic                                item_stall,
  input  nbv_pkg::item_t                      item,
  input  logic                                result_valid,
  input  logic                                result_stall,
  input  nbv_pkg::result_t                    result,
  input  logic                                cfg_we,
  input  logic [nbv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nbv_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                  fail_count,
  output int                                  pending
);

  localparam logic [63:0] POS_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;

  typedef logic [63:0] vec_t [BODIES];

  logic [40:0] h_reg, band_reg;
  logic [31:0] min_steps_reg;
  logic [40:0] mass [BODIES];
  vec_t px, py, vx, vy, ax, ay;
  logic        seen [BODIES];
  logic [31:0] steps_done;
  logic        accel_ok;
  nbv_pkg::result_t expected_beats [$];

  assign pending = expected_beats.size();

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? NEG_MAX : POS_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? NEG_MAX : POS_MAX;
    return s[63:0];
  endfunction

  // Q24.40 product, round half away from zero, saturating
  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0]  ma, mb, m;
    logic [127:0] p;
    logic         neg;
    neg = a[63] ^ b[63];
    ma = a[63] ? 64'd0 - a : a;
    mb = b[63] ? 64'd0 - b : b;
    p = {64'd0, ma} * {64'd0, mb} + (128'd1 << 39);
    if (|p[127:104]) return neg ? NEG_MAX : POS_MAX;
    m = p[103:40];
    if (neg) return m[63] ? NEG_MAX : 64'd0 - m;
    return m[63] ? POS_MAX : m;
  endfunction

  function automatic logic [63:0] fx_sqrt(input logic [63:0] r2);
    logic [127:0] n, c;
    logic [63:0]  res, cand;
    n = {64'd0, r2} << 40;
    res = 64'd0;
    for (int b = 51; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      c = {64'd0, cand} * {64'd0, cand};
      if (c <= n) res = cand;
    end
    return res;
  endfunction

  function automatic logic [63:0] fx_recip(input logic [63:0] r3);
    logic [127:0] q;
    if ($signed(r3) <= 64'sd131072) return POS_MAX;
    q = (128'd1 << 80) / {64'd0, r3};
    return {1'b0, q[62:0]};
  endfunction

  task automatic gravity(output vec_t gx, output vec_t gy);
    logic [63:0] dx, dy, r2, inv, sx, sy;
    for (int i = 0; i < BODIES; i++) begin
      sx = 64'd0;
      sy = 64'd0;
      for (int j = 0; j < BODIES; j++) begin
        if (i != j) begin
          dx = sat_sub(px[i], px[j]);
          dy = sat_sub(py[i], py[j]);
          r2 = sat_add(fx_mul(dx, dx), fx_mul(dy, dy));
          // coincident pair pulls nothing
          if (r2 != 64'd0) begin
            inv = fx_recip(fx_mul(r2, fx_sqrt(r2)));
            sx = sat_sub(sx, fx_mul(fx_mul({23'd0, mass[j]}, dx), inv));
            sy = sat_sub(sy, fx_mul(fx_mul({23'd0, mass[j]}, dy), inv));
          end
        end
      end
      gx[i] = sx;
      gy[i] = sy;
    end
  endtask

  task automatic advance(input nbv_pkg::item_t it);
    vec_t             nx, ny;
    nbv_pkg::result_t r;
    logic [63:0]      h, hh, hh2, band;
    if (it.operation == nbv_pkg::OP_LOAD) begin
      if (it.body_index < BODIES) begin
        mass[it.body_index] = it.body_mass;
        px[it.body_index] = it.load_pos_x;
        py[it.body_index] = it.load_pos_y;
        vx[it.body_index] = it.load_vel_x;
        vy[it.body_index] = it.load_vel_y;
      end
      accel_ok = 1'b0;
      return;
    end
    if (!accel_ok) gravity(ax, ay);
    band = {23'd0, band_reg};
    for (int i = 0; i < BODIES; i++) begin
      r.out_body = i[3:0];
      r.out_pos_x = px[i];
      r.out_pos_y = py[i];
      r.period_hit = 1'b0;
      if (i >= 1 && !seen[i] && $signed(py[i]) < $signed(band) &&
          $signed(py[i]) > -$signed(band) && $signed(px[i]) > 0 &&
          steps_done > min_steps_reg) begin
        r.period_hit = 1'b1;
        seen[i] = 1'b1;
      end
      r.out_step = steps_done;
      r.last = (i == BODIES - 1);
      expected_beats.push_back(r);
    end
    h = {23'd0, h_reg};
    hh = fx_mul(h, h) >> 1;
    hh2 = h >> 1;
    for (int i = 0; i < BODIES; i++) begin
      px[i] = sat_add(px[i], sat_add(fx_mul(h, vx[i]), fx_mul(hh, ax[i])));
      py[i] = sat_add(py[i], sat_add(fx_mul(h, vy[i]), fx_mul(hh, ay[i])));
    end
    gravity(nx, ny);
    for (int i = 0; i < BODIES; i++) begin
      vx[i] = sat_add(vx[i], fx_mul(hh2, sat_add(ax[i], nx[i])));
      vy[i] = sat_add(vy[i], fx_mul(hh2, sat_add(ay[i], ny[i])));
      ax[i] = nx[i];
      ay[i] = ny[i];
    end
    accel_ok = 1'b1;
    steps_done = steps_done + 32'd1;
  endtask

  always @(posedge clk) begin
    nbv_pkg::result_t exp_r;
    logic             bad;
    if (rst) begin
      h_reg = nbv_pkg::STEP_SIZE_RST;
      band_reg = nbv_pkg::PERIOD_BAND_RST;
      min_steps_reg = nbv_pkg::PERIOD_MIN_STEPS_RST;
      for (int i = 0; i < BODIES; i++) seen[i] = 1'b0;
      steps_done = 32'd0;
      accel_ok = 1'b0;
      expected_beats.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          nbv_pkg::REG_STEP_SIZE:        h_reg = cfg_data;
          nbv_pkg::REG_PERIOD_BAND:      band_reg = cfg_data;
          nbv_pkg::REG_PERIOD_MIN_STEPS: min_steps_reg = cfg_data[31:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_beats.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat: body %0d x %h y %h", result.out_body,
                     result.out_pos_x, result.out_pos_y);
        end else begin
          exp_r = expected_beats.pop_front();
          bad = (result.out_body !== exp_r.out_body) ||
                (result.out_pos_x !== exp_r.out_pos_x) ||
                (result.out_pos_y !== exp_r.out_pos_y) ||
                (result.period_hit !== exp_r.period_hit) ||
                (result.out_step !== exp_r.out_step) ||
                (result.last !== exp_r.last);
          if (bad) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: exp body %0d x %h y %h hit %b step %0d last %b",
                        " | got body %0d x %h y %h hit %b step %0d last %b"},
                       exp_r.out_body, exp_r.out_pos_x, exp_r.out_pos_y, exp_r.period_hit,
                       exp_r.out_step, exp_r.last, result.out_body, result.out_pos_x,
                       result.out_pos_y, result.period_hit, result.out_step, result.last);
          end
        end
      end
      if (item_valid && !item_stall) advance(item);
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top testbench for the N-body Verlet step core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int BODIES = 8;
  localparam int SETTLE = 25000;      // a step keeps working after its last beat
  localparam longint LIMIT = 8000000;
  localparam logic [40:0] ONE = 41'h100_0000_0000;

  logic                  clk, rst;
  logic                  item_valid, item_stall;
  nbv_pkg::item_t        item;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  nbv_pkg::result_t      result;
  logic                  cfg_we;
  logic [nbv_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [nbv_pkg::CFG_DATA_W-1:0] cfg_data;
  int                    fail_count, pending;
  int                    send_pct, recv_pct, n_items;
  longint                cycles = 0;

  nbody_verlet_step_core #(.BODIES(BODIES)) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  nbv_checker #(.BODIES(BODIES)) chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_pct);
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_signed(input int bits);
    logic [63:0] v;
    v = rand64() >> (64 - bits);
    return $urandom_range(1) ? 64'd0 - v : v;
  endfunction

  task automatic send(input nbv_pkg::item_t it);
    while ($urandom_range(99) < send_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (it.operation == nbv_pkg::OP_STEP || it.body_index < BODIES) n_items++;
  endtask

  task automatic load(input logic [3:0] idx, input logic [40:0] m, input logic [63:0] x,
                      input logic [63:0] y, input logic [63:0] u, input logic [63:0] w);
    nbv_pkg::item_t it;
    it.operation = nbv_pkg::OP_LOAD;
    it.body_index = idx;
    it.body_mass = m;
    it.load_pos_x = x;
    it.load_pos_y = y;
    it.load_vel_x = u;
    it.load_vel_y = w;
    send(it);
  endtask

  task automatic step();
    nbv_pkg::item_t it;
    it = '0;
    it.operation = nbv_pkg::OP_STEP;
    it.body_index = 4'($urandom);
    it.body_mass = 41'({$urandom, $urandom});
    it.load_pos_x = rand64();
    it.load_pos_y = rand64();
    it.load_vel_x = rand64();
    it.load_vel_y = rand64();
    send(it);
  endtask

  // registers change only with the core drained and settled
  task automatic set_regs(input logic [40:0] h, input logic [40:0] band,
                          input logic [31:0] min_steps);
    item_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= nbv_pkg::REG_STEP_SIZE;
    cfg_data <= h;
    @(posedge clk);
    cfg_index <= nbv_pkg::REG_PERIOD_BAND;
    cfg_data <= band;
    @(posedge clk);
    cfg_index <= nbv_pkg::REG_PERIOD_MIN_STEPS;
    cfg_data <= {9'd0, min_steps};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // a small system: heavy center near the origin, light bodies on rough orbits
  task automatic load_orbits();
    for (int i = 0; i < BODIES; i++) begin
      if (i == 0)
        load(4'd0, ONE, rand_signed(30), rand_signed(30), rand_signed(30), rand_signed(30));
      else
        load(i[3:0], {9'd0, $urandom} >> $urandom_range(0, 10),
             rand_signed(43), rand_signed(37), rand_signed(38), rand_signed(41));
    end
  endtask

  task automatic load_wild();
    for (int i = 0; i < BODIES; i++)
      load(i[3:0], $urandom_range(9) == 0 ? ONE : {1'b0, $urandom, 8'($urandom)},
           rand64(), rand64(), rand64(), rand64());
  endtask

  initial begin
    logic [40:0] h, band;
    logic [31:0] mins;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = nbv_pkg::REG_STEP_SIZE;
    cfg_data = '0;
    n_items = 0;
    send_pct = 37;
    recv_pct = 76;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, coincident pair, near-zero distance, ignored indexes
    set_regs(nbv_pkg::STEP_SIZE_RST, ONE, 32'd0);
    load(4'd0, ONE, 64'd0, 64'd0, 64'd0, 64'd0);
    load(4'd1, 41'd0, 64'h7fff_ffff_ffff_ffff, 64'd0, 64'd0, 64'd0);
    load(4'd2, 41'd1, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff,
         64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
    load(4'd3, 41'h0ff_ffff_ffff, 64'h300_0000_0000, 64'hffff_ffff_ffff_ffff, 64'd0,
         64'h100_0000_0000);
    load(4'd4, 41'h0ff_ffff_ffff, 64'h300_0000_0000, 64'hffff_ffff_ffff_ffff, 64'd0,
         64'hffff_ff00_0000_0000);
    load(4'd5, ONE, 64'h200_0000_0000, 64'h8000_0000_0000, 64'h1, 64'h1);
    load(4'd6, ONE, 64'h200_0010_0000, 64'h8000_0000_0000, 64'h1, 64'h1);
    load(4'd7, 41'h1_0000, 64'h100_0000_0000, 64'hffff_ffff_ffff_ffff,
         64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    load(4'd15, '1, '1, '1, '1, '1);
    load(4'd8, 41'd0, '0, '0, '0, '0);
    step();
    step();
    load(4'd1, ONE, 64'h080_0000_0000, 64'd0, 64'd0, 64'h100_0000_0000);
    step();
    set_regs(41'd1, 41'd0, 32'hffff_ffff);
    step();
    step();
    set_regs(ONE, 41'h0_1234_5678, 32'd1);
    load_orbits();
    step();
    step();

    // random systems, mostly well-formed load sets followed by steps
    while (n_items < 130) begin
      if (n_items < 45) begin
        send_pct = 37;
        recv_pct = 76;
      end else if (n_items < 90) begin
        send_pct = 76;
        recv_pct = 37;
      end else begin
        send_pct = 0;
        recv_pct = 0;
      end
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(3))
          0: h = 41'd1;
          1: h = ONE;
          2: h = 41'($urandom_range(1, 32'hffff_ffff)) << $urandom_range(0, 6);
          default: h = nbv_pkg::STEP_SIZE_RST;
        endcase
        band = $urandom_range(2) == 0 ? ONE : {9'd0, $urandom} << $urandom_range(0, 8);
        case ($urandom_range(2))
          0: mins = 32'd0;
          1: mins = $urandom_range(0, 10);
          default: mins = 32'hffff_ffff;
        endcase
        set_regs(h, band, mins);
      end
      if ($urandom_range(4) == 0) load_wild();
      else load_orbits();
      if ($urandom_range(2) == 0)
        load(4'($urandom_range(8, 15)), '1, rand64(), rand64(), rand64(), rand64());
      repeat ($urandom_range(1, 3)) step();
      // broken sequence: one body reloaded mid-run
      if ($urandom_range(3) == 0) begin
        load(4'($urandom_range(0, BODIES - 1)), {9'd0, $urandom}, rand_signed(43),
             rand_signed(37), rand_signed(38), rand_signed(41));
        step();
      end
    end

    item_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== nbody_verlet_step_core.f =====
sv/nbv_pkg.sv
sv/nbv_mulq.sv
sv/nbody_verlet_step_core.sv
tb/sv/nbv_checker.sv
tb/sv/tb_top.sv
